// ----- rtl/core/lcg48_random_modulo_defines.svh -----
// ----------------------------------------------------------------------------
// lcg48_random_modulo_defines.svh
// Assertion macros shared by the checker of the random modulo generator.
// ----------------------------------------------------------------------------
`ifndef LCG48_RANDOM_MODULO_DEFINES_SVH
`define LCG48_RANDOM_MODULO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCG48_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCG48_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/lcg48_pkg.sv -----
// ----------------------------------------------------------------------------
// lcg48_pkg
// Types and constants of the 48-bit LCG random modulo generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

    // Multiplier 0x5DEECE66D split into its low 32 bits and top 3 bits.
    localparam logic [31:0] LCG_MULT_LO = 32'hDEEC_E66D;
    localparam logic [2:0]  LCG_MULT_HI = 3'h5;
    localparam logic [47:0] LCG_INC     = 48'h0000_0000_000B;
    localparam logic [15:0] SEED_HIGH   = 16'h0DAB;
    localparam logic [31:0] MOD_MAX     = 32'h8000_0000;
    localparam int          DIV_STEPS   = 64;
    localparam int          CNT_W       = $clog2(DIV_STEPS);
    localparam int          CFG_ADDR_W  = 3;
    localparam logic        REG_SEED    = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic        load;
        logic [31:0] seed;
    } cfg_load_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] modulus;
    } q_item_t;

endpackage

// ----- rtl/core/lcg48_front.sv -----
// ----------------------------------------------------------------------------
// lcg48_front
// Accepts requests, clamps the modulus to 1..2^31 and queues it (2 deep).
// ----------------------------------------------------------------------------
module lcg48_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    output lcg48_pkg::q_item_t  q_head,
    input  logic                q_pop
);
    import lcg48_pkg::*;

    logic [31:0] mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    logic [31:0] mod_clamped;

    // Zero and anything above 2^31 both mean 2^31.
    assign mod_clamped = ((s_tdata == '0) || (s_tdata > MOD_MAX)) ? MOD_MAX : s_tdata;

    assign s_tready       = (count_reg != 2'd2);
    assign push           = s_tvalid && s_tready;
    assign pop            = q_pop && (count_reg != 2'd0);
    assign q_head.valid   = (count_reg != 2'd0);
    assign q_head.modulus = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= mod_clamped;
        end
    end

endmodule

// ----- rtl/core/lcg48_back.sv -----
// ----------------------------------------------------------------------------
// lcg48_back
// Advances the generator, divides the sign-extended draw by the modulus one
// quotient bit per cycle and holds the remainder in the output register.
// ----------------------------------------------------------------------------
module lcg48_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lcg48_pkg::cfg_load_t  cfg,
    input  lcg48_pkg::q_item_t    q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);
    import lcg48_pkg::*;

    back_state_t       fsm_reg, fsm_next;
    logic [47:0]       state_reg, state_next;
    logic [31:0]       mod_reg, mod_next;
    logic [63:0]       p0_reg, p0_next;
    logic [15:0]       p1_reg, p1_next;
    logic [63:0]       dvd_reg, dvd_next;
    logic [31:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [30:0]       out_data_reg, out_data_next;
    logic [47:0]       adv_state;
    logic [32:0]       trial;
    logic [31:0]       cross_a;
    logic [31:0]       cross_b;

    // Only the low 16 bits of the cross products reach the 48-bit state.
    assign cross_a   = LCG_MULT_LO[15:0] * state_reg[47:32];
    assign cross_b   = {29'd0, LCG_MULT_HI} * {16'd0, state_reg[15:0]};
    assign adv_state = p0_reg[47:0] + {p1_reg, 32'd0} + LCG_INC;
    assign trial     = {rem_reg, dvd_reg[63]};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    always_comb begin
        fsm_next       = fsm_reg;
        state_next     = state_reg;
        mod_next       = mod_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;

        unique case (fsm_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    q_pop    = 1'b1;
                    mod_next = q_head.modulus;
                    fsm_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                p0_next  = LCG_MULT_LO * state_reg[31:0];
                fsm_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                p1_next  = cross_a[15:0] + cross_b[15:0];
                fsm_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = adv_state;
                dvd_next   = {{32{adv_state[47]}}, adv_state[47:16]};
                rem_next   = '0;
                cnt_next   = '0;
                fsm_next   = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= {1'b0, mod_reg}) begin
                    rem_next = trial[31:0] - mod_reg;
                end else begin
                    rem_next = trial[31:0];
                end
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    fsm_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rem_reg[30:0];
                    fsm_next       = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase

        // Seed writes must arrive only while no request is in flight; the block does not enforce it.
        if (cfg.load) begin
            state_next = {SEED_HIGH, cfg.seed};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= ST_IDLE;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            fsm_reg       <= fsm_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mod_reg      <= mod_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/lcg48_random_modulo.sv -----
// ----------------------------------------------------------------------------
// lcg48_random_modulo
// 48-bit jrand48-style generator whose draws are reduced modulo a requested
// range.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                     Moves
//  -------  ------------------------  ----------------------------------------
//  request  s_tvalid/s_tready/s_tdata modulus (0 or above 2^31 means 2^31)
//  result   m_tvalid/m_tready/m_tdata random_value, 31 bits, bit 31 zero
//  config   psel/penable/pwrite/...   seed_value at byte address 0
//
//  A request that heads the queue is popped, the split 48-bit multiply-add
//  advances the state, the restoring divider yields one quotient bit per cycle
//  and the result is loaded into the output register once that is free.
//  Reset (aresetn low, synchronous) zeroes the generator state and seed register
//  and empties the request queue and output register. The two-deep queue keeps
//  taking requests while the divider works; a stalled result holds the back end.
//
module lcg48_random_modulo (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel. s_tdata: [31:0] modulus.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,
    // Result channel. m_tdata: [30:0] random_value, [31] zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcg48_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lcg48_pkg::*;

    logic [31:0] seed_value_reg, seed_value_next;
    logic        wr_en;
    logic        seed_sel;
    cfg_load_t   cfg;
    q_item_t     q_head;
    logic        q_pop;

    // Registers sit on 32-bit words, so the word index is the top address bit.
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign seed_sel = (paddr[CFG_ADDR_W-1] == REG_SEED);

    // A seed write both updates the readable register and reloads the state.
    assign cfg.load = wr_en && seed_sel;
    assign cfg.seed = pwdata;

    assign seed_value_next = cfg.load ? pwdata : seed_value_reg;
    assign prdata          = seed_sel ? seed_value_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_value_reg <= '0;
        end else begin
            seed_value_reg <= seed_value_next;
        end
    end

    // Front end: takes request transactions, clamps the modulus and queues it.
    lcg48_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // Back end: advances the generator, divides, and drives result transactions.
    lcg48_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/lcg48_random_modulo_checker.sv -----
// ----------------------------------------------------------------------------
// lcg48_random_modulo_checker
// Port-level checks of the random modulo generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcg48_random_modulo_defines.svh"

module lcg48_random_modulo_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [31:0]                       m_tdata,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [lcg48_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [31:0]                       pwdata,
    input logic [31:0]                       prdata,
    input logic                              pready
);
    import lcg48_pkg::*;

    logic m_stall;
    logic seed_sel;
    logic seed_wr;

    assign m_stall  = m_tvalid && !m_tready;
    assign seed_sel = (paddr[CFG_ADDR_W-1] == REG_SEED);
    assign seed_wr  = psel && penable && pwrite && seed_sel;

    // A stalled result transaction keeps its data.
    `LCG48_ASSERT_NXT(a_result_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata))

    // The remainder is below 2^31, so the pad bit stays zero.
    `LCG48_ASSERT_IMP(a_result_range, aclk, aresetn, m_tvalid, m_tdata[31] == 1'b0)

    // The configuration port never inserts wait states.
    `LCG48_ASSERT_IMP(a_no_wait, aclk, aresetn, psel, pready)

    // A seed write is visible on a read of the seed register in the next cycle.
    `LCG48_ASSERT_NXT(a_seed_readback, aclk, aresetn, seed_wr, !seed_sel || prdata == $past(pwdata))

endmodule

bind lcg48_random_modulo lcg48_random_modulo_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 48-bit LCG random modulo generator: requests
// with a wide mix of moduli against a built-in generator model, with stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcg48_pkg::*;

    // Register map: the seed at byte address 0, nothing at address 4.
    localparam logic [CFG_ADDR_W-1:0] SEED_ADDR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = 3'd4;

    localparam logic [47:0] LCG_MULTIPLIER = 48'h5_DEEC_E66D;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          PHASE_ITEMS    = 250;
    localparam int          DRAIN_CYCLES   = 100;

    // Idle patterns: sender 15 / receiver 50, then the reverse, then none.
    localparam int IDLE_SEND_HEAVY_RECV = 0;
    localparam int IDLE_RECV_HEAVY_SEND = 1;
    localparam int IDLE_NONE            = 2;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] modulus
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [30:0] random_value, [31] zero
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Moduli waiting to be sent and draws waiting to come back.
    logic [31:0] pending_moduli[$];
    logic [30:0] expected_draws[$];

    // The generator model: the seed register and the 48-bit state.
    logic [31:0] seed_model = '0;
    logic [47:0] gen_state  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int draws_checked  = 0;
    int requests_sent  = 0;
    int seed_loads     = 0;

    lcg48_random_modulo u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Advances the generator once and reduces the draw. Bits 47..16 of the new
    // state are a signed word; the sign-extended 64-bit pattern is then taken
    // as unsigned before the remainder, so negative draws land in odd places.
    // A zero modulus, or one above 2^31, is treated as 2^31.
    function automatic logic [30:0] draw_random_value(input logic [31:0] modulus);
        logic [31:0] range;
        logic [63:0] draw;
        logic [63:0] remainder;
        range = (modulus == '0 || modulus > MOD_MAX) ? MOD_MAX : modulus;
        gen_state = gen_state * LCG_MULTIPLIER + LCG_INC;
        draw = {{32{gen_state[47]}}, gen_state[47:16]};
        remainder = draw % {32'd0, range};
        return remainder[30:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] expected_val,
                                   input logic [31:0] actual_val);
        $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                 $realtime, what, expected_val, actual_val);
        mismatch_count++;
    endtask

    // Request driver. A new transaction is offered only once the previous one
    // has been taken, and each offer may be held back by the sender's idling.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_moduli.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= pending_moduli.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side backpressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor. All values are sampled at the rising edge, before the edge's
    // own updates land, so the model sees exactly what the block saw.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == SEED_ADDR) begin
                seed_model = pwdata;
                gen_state  = {SEED_HIGH, pwdata};
            end
            if (psel && penable && !pwrite && pready && paddr == SEED_ADDR &&
                prdata != seed_model) begin
                report_mismatch("seed readback", seed_model, prdata);
            end
            if (s_tvalid && s_tready) begin
                expected_draws.push_back(draw_random_value(s_tdata));
                requests_sent++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    logic [30:0] want;
                    want = expected_draws.pop_front();
                    if (m_tdata[30:0] != want) begin
                        report_mismatch("random_value", {1'b0, want}, {1'b0, m_tdata[30:0]});
                    end
                    draws_checked++;
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that closes the access cycle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == SEED_ADDR) seed_loads++;
    endtask

    // APB read; the monitor compares the returned data.
    task automatic read_reg(input logic [CFG_ADDR_W-1:0] addr);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits, checking at falling edges, until everything sent has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_moduli.size() != 0 || s_tvalid || expected_draws.size() != 0);
    endtask

    task automatic set_idle_pattern(input int pattern);
        case (pattern)
            IDLE_SEND_HEAVY_RECV: begin
                send_idle_pct = 15;
                recv_idle_pct = 50;
            end
            IDLE_RECV_HEAVY_SEND: begin
                send_idle_pct = 50;
                recv_idle_pct = 15;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Random moduli lean toward the interesting ranges: zero, exactly 2^31,
    // above 2^31 (saturated), tiny ranges, powers of two and values just
    // under 2^31. Plain 32-bit words make sure every bit is exercised.
    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1:       return MOD_MAX;
            2:       return $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
            3:       return $urandom_range(16, 1);
            4:       return 32'd1 << $urandom_range(31);
            5:       return MOD_MAX - $urandom_range(3, 1);
            default: return $urandom();
        endcase
    endfunction

    // Stimulus sequence.
    initial begin
        logic [31:0] directed_moduli[$];
        logic [31:0] phase_seed;
        directed_moduli = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000,
                            32'h4000_0000, 32'd1000000007};

        set_idle_pattern(IDLE_SEND_HEAVY_RECV);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // With no seed written yet the generator runs from an all-zero state,
        // and the seed register must read back as zero.
        read_reg(SEED_ADDR);
        pending_moduli.push_back(32'd0);
        pending_moduli.push_back(32'd1);
        pending_moduli.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Load a seed, then write the unused address: that write must leave
        // both the seed register and the generator state alone.
        write_reg(SEED_ADDR, 32'h1234_5678);
        write_reg(UNUSED_ADDR, 32'hDEAD_BEEF);
        read_reg(SEED_ADDR);
        foreach (directed_moduli[i]) pending_moduli.push_back(directed_moduli[i]);
        wait_drained();

        // Random phases, each with a fresh seed; the first and third use the
        // seed extremes. Halfway through each phase the sender holds off
        // until every outstanding result has come back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idle_pattern(phase / 2);
            case (phase)
                0:       phase_seed = 32'hFFFF_FFFF;
                2:       phase_seed = 32'h0000_0000;
                default: phase_seed = $urandom();
            endcase
            write_reg(SEED_ADDR, phase_seed);
            read_reg(SEED_ADDR);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drained();
                pending_moduli.push_back(pick_modulus());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d draws from %0d requests across %0d seed loads,",
                 draws_checked, requests_sent, seed_loads);
        $display("with zero, saturated, tiny and full-width moduli under mixed stalls.");
        if (mismatch_count == 0 && expected_draws.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", expected_draws.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lcg48_pkg.sv
rtl/core/lcg48_front.sv
rtl/core/lcg48_back.sv
rtl/core/lcg48_random_modulo.sv
rtl/core/lcg48_random_modulo_checker.sv
tb/sv/testbench.sv
